FILE: rtl/frle_pkg.sv
package frle_pkg;

  localparam int unsigned AddrBitsDefault = 32;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 32;

  localparam logic [CfgIdxBits-1:0] CfgBaseAddress  = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgStartAddress = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgEndAddress   = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgLiteralBase  = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgZeroBase     = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgNopBase      = 3'd5;

  localparam logic [7:0]  LiteralBaseReset = 8'd0;
  localparam logic [7:0]  ZeroBaseReset    = 8'd128;
  localparam logic [7:0]  NopBaseReset     = 8'd192;
  localparam logic [31:0] NopWord          = 32'h7040_0101;

  typedef enum logic [1:0] {
    ModeStart  = 2'd0,
    ModeByte   = 2'd1,
    ModeFinish = 2'd2,
    ModeIgnore = 2'd3
  } mode_e;

  // literal run bookkeeping carried between items
  typedef struct packed {
    logic [10:0] bytes_left;
    logic [23:0] partial_word;
    logic        error_seen;
  } run_state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] word_address;
    logic [31:0] word_value;
    logic [30:0] repeat_count;
    logic        last_run;
    logic        format_error;
  } result_t;

endpackage

FILE: rtl/frle_if.sv
interface frle_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] stream_byte;

  modport source (output valid, output mode, output stream_byte, input ready);
  modport sink (input valid, input mode, input stream_byte, output ready);
endinterface

interface frle_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] word_address;
  logic [31:0] word_value;
  logic [30:0] repeat_count;
  logic        last_run;
  logic        format_error;

  modport source (
    output valid, output word_address, output word_value, output repeat_count,
    output last_run, output format_error, input ready
  );
  modport sink (
    input valid, input word_address, input word_value, input repeat_count,
    input last_run, input format_error, output ready
  );
endinterface

FILE: rtl/frle_step.sv
module frle_step import frle_pkg::*; #(
  parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
  input  logic [1:0]           mode_i,
  input  logic [7:0]           stream_byte_i,
  input  logic [ADDR_BITS-1:0] base_address_i,
  input  logic [ADDR_BITS-1:0] start_address_i,
  input  logic [ADDR_BITS-1:0] end_address_i,
  input  logic [7:0]           literal_base_i,
  input  logic [7:0]           zero_base_i,
  input  logic [7:0]           nop_base_i,
  input  logic [ADDR_BITS-1:0] next_address_i,
  input  run_state_t           run_state_i,
  output logic [ADDR_BITS-1:0] next_address_o,
  output run_state_t           run_state_o,
  output result_t              result_o
);

  localparam int unsigned SumBits = (ADDR_BITS + 1 > 33) ? ADDR_BITS + 1 : 33;

  logic [ADDR_BITS-1:0] fill_from;
  logic [ADDR_BITS-1:0] fill_to;
  logic [ADDR_BITS-1:0] fill_diff;
  logic [SumBits-1:0]   fill_sum;
  logic                 fill_active;
  logic [30:0]          fill_count;
  logic [ADDR_BITS-1:0] fill_next;
  logic [8:0]           op_len;
  logic [7:0]           op_base;
  logic [ADDR_BITS-1:0] run_next;
  logic [31:0]          cur_address;

  // one fill unit shared by start and finish
  always_comb begin
    fill_from   = (mode_i == ModeStart) ? base_address_i : next_address_i;
    fill_to     = (mode_i == ModeStart) ? start_address_i : end_address_i;
    fill_active = fill_to > fill_from;
    fill_diff   = fill_to - fill_from;
    fill_sum    = SumBits'(fill_diff) + SumBits'(3);
    fill_count  = fill_active ? fill_sum[32:2] : 31'd0;
    fill_next   = fill_active ? fill_from + (fill_sum[ADDR_BITS-1:0] & ~ADDR_BITS'(3))
                              : fill_from;
  end

  // run length of an opcode against the base of its class
  always_comb begin
    if (stream_byte_i < zero_base_i) begin
      op_base = literal_base_i;
    end else if (stream_byte_i < nop_base_i) begin
      op_base = zero_base_i;
    end else begin
      op_base = nop_base_i;
    end
    op_len   = {1'b0, stream_byte_i} - {1'b0, op_base} + 9'd1;
    run_next = next_address_i + {{(ADDR_BITS-11){1'b0}}, op_len, 2'b00};
  end

  assign cur_address = 32'(next_address_i);

  always_comb begin
    next_address_o = next_address_i;
    run_state_o    = run_state_i;
    result_o       = '0;
    case (mode_i)
      ModeStart: begin
        result_o.valid        = 1'b1;
        result_o.word_address = 32'(base_address_i);
        result_o.repeat_count = fill_count;
        next_address_o        = fill_next;
        run_state_o           = '0;
      end
      ModeFinish: begin
        result_o.valid        = 1'b1;
        result_o.word_address = cur_address;
        result_o.repeat_count = fill_count;
        result_o.last_run     = 1'b1;
        result_o.format_error = run_state_i.error_seen || (run_state_i.bytes_left != '0);
        next_address_o        = fill_next;
        run_state_o           = '0;
      end
      ModeByte: begin
        if (run_state_i.bytes_left != '0) begin
          run_state_o.bytes_left = run_state_i.bytes_left - 11'd1;
          if (run_state_i.bytes_left[1:0] == 2'b01) begin
            // last byte of a big-endian literal word
            result_o.valid         = 1'b1;
            result_o.word_address  = cur_address;
            result_o.word_value    = {run_state_i.partial_word, stream_byte_i};
            result_o.repeat_count  = 31'd1;
            next_address_o         = next_address_i + ADDR_BITS'(4);
            run_state_o.partial_word = '0;
          end else begin
            run_state_o.partial_word = {run_state_i.partial_word[15:0], stream_byte_i};
          end
        end else if (stream_byte_i < zero_base_i) begin
          if (stream_byte_i < literal_base_i) begin
            run_state_o.error_seen = 1'b1;
          end else begin
            run_state_o.bytes_left   = {op_len, 2'b00};
            run_state_o.partial_word = '0;
          end
        end else begin
          result_o.valid        = 1'b1;
          result_o.word_address = cur_address;
          result_o.word_value   = (stream_byte_i < nop_base_i) ? 32'd0 : NopWord;
          result_o.repeat_count = 31'(op_len);
          next_address_o        = run_next;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/frle_out_reg.sv
module frle_out_reg import frle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  result_t    result_i,
  output logic       free_o,
  frle_out_if.source out_if
);

  logic    valid_q;
  logic    valid_d;
  result_t data_q;

  assign free_o  = !valid_q || out_if.ready;
  assign valid_d = (load_i && result_i.valid) ? 1'b1 : (out_if.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && result_i.valid) begin
      data_q <= result_i;
    end
  end

  assign out_if.valid        = valid_q;
  assign out_if.word_address = data_q.word_address;
  assign out_if.word_value   = data_q.word_value;
  assign out_if.repeat_count = data_q.repeat_count;
  assign out_if.last_run     = data_q.last_run;
  assign out_if.format_error = data_q.format_error;

endmodule

FILE: rtl/firmware_run_length_expander.sv
// Run-length firmware expander: takes one item per clock (start, coded byte,
// finish or ignore) and gives at most one run per item, in the cycle after it
// is accepted; a run is address, word value and repeat count, where literal
// words come out as runs of one. The input stays ready every cycle unless a
// run is held in the output register and the sink is stalling. The figure is
// set by the next-address loop, which closes through a compare, a subtract, a
// round-up add and an add over ADDR_BITS bits. Configuration must be written
// through cfg_we_i while no item is in flight (not enforced by the block);
// addresses wrap at ADDR_BITS bits; the run address port shows their low 32.
module firmware_run_length_expander import frle_pkg::*; #(
  parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  frle_in_if.sink                in_if,
  frle_out_if.source             out_if
);

  logic [31:0] base_address_q;
  logic [31:0] start_address_q;
  logic [31:0] end_address_q;
  logic [7:0]  literal_base_q;
  logic [7:0]  zero_base_q;
  logic [7:0]  nop_base_q;

  logic [ADDR_BITS-1:0] next_address_q;
  logic [ADDR_BITS-1:0] next_address_d;
  run_state_t           run_state_q;
  run_state_t           run_state_d;
  result_t              result;
  logic                 out_free;
  logic                 accept;

  assign in_if.ready = out_free;
  assign accept      = in_if.valid && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_address_q  <= '0;
      start_address_q <= '0;
      end_address_q   <= '0;
      literal_base_q  <= LiteralBaseReset;
      zero_base_q     <= ZeroBaseReset;
      nop_base_q      <= NopBaseReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgBaseAddress:  base_address_q  <= cfg_data_i;
        CfgStartAddress: start_address_q <= cfg_data_i;
        CfgEndAddress:   end_address_q   <= cfg_data_i;
        CfgLiteralBase:  literal_base_q  <= cfg_data_i[7:0];
        CfgZeroBase:     zero_base_q     <= cfg_data_i[7:0];
        CfgNopBase:      nop_base_q      <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_address_q <= '0;
      run_state_q    <= '0;
    end else if (accept) begin
      next_address_q <= next_address_d;
      run_state_q    <= run_state_d;
    end
  end

  frle_step #(
    .ADDR_BITS(ADDR_BITS)
  ) u_step (
    .mode_i          (in_if.mode),
    .stream_byte_i   (in_if.stream_byte),
    .base_address_i  (ADDR_BITS'(base_address_q)),
    .start_address_i (ADDR_BITS'(start_address_q)),
    .end_address_i   (ADDR_BITS'(end_address_q)),
    .literal_base_i  (literal_base_q),
    .zero_base_i     (zero_base_q),
    .nop_base_i      (nop_base_q),
    .next_address_i  (next_address_q),
    .run_state_i     (run_state_q),
    .next_address_o  (next_address_d),
    .run_state_o     (run_state_d),
    .result_o        (result)
  );

  frle_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .result_i (result),
    .free_o   (out_free),
    .out_if   (out_if)
  );

`ifndef ASSERT_OFF
  a_finish_gives_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_if.mode == ModeFinish) |=> out_if.valid && out_if.last_run)
    else $error("finish item did not give a last run");

  a_error_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.format_error |-> out_if.last_run)
    else $error("format error flagged on a run that is not last");

  a_ignored_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_if.mode == ModeIgnore) |=> !out_if.valid)
    else $error("ignored item produced a run");

  a_literal_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_if.mode == ModeByte) && (run_state_q.bytes_left != '0)
    |=> run_state_q.bytes_left == $past(run_state_q.bytes_left) - 11'd1)
    else $error("literal byte count did not step down");
`endif

endmodule

FILE: sim/testbench.sv
module testbench import frle_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] start;
    logic [31:0] stop;
    logic [7:0]  lit;
    logic [7:0]  zero;
    logic [7:0]  nop;
  } cfg_t;

  // want.valid marks a row whose run is typed in by hand
  typedef struct packed {
    logic [1:0] phase;
    mode_e      mode;
    logic [7:0] code;
    result_t    want;
  } row_t;

  localparam int NumRows = 28;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  frle_in_if  in_if ();
  frle_out_if out_if ();

  firmware_run_length_expander u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  // expander registers as the block holds them
  logic [31:0] cfg_base  = '0;
  logic [31:0] cfg_start = '0;
  logic [31:0] cfg_stop  = '0;
  logic [7:0]  cfg_lit   = LiteralBaseReset;
  logic [7:0]  cfg_zero  = ZeroBaseReset;
  logic [7:0]  cfg_nop   = NopBaseReset;

  // decoder state
  logic [31:0] next_addr = '0;
  logic [10:0] lit_left  = '0;
  logic [23:0] partial   = '0;
  logic        err_seen  = 1'b0;

  result_t want_q [$];
  result_t pin_q [$];
  bit      failed = 1'b0;
  bit      calm   = 1'b0;
  int      hold_cycles = 0;

  row_t dir_rows [NumRows];
  cfg_t phase_cfg [4];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [30:0] fill_words(logic [31:0] from, logic [31:0] to);
    logic [32:0] d;
    if (to <= from) return '0;
    d = {1'b0, to} - {1'b0, from} + 33'd3;
    return 31'(d >> 2);
  endfunction

  function automatic result_t expand_item(mode_e m, logic [7:0] b);
    result_t     r;
    logic [31:0] at;
    logic [30:0] n;
    r = '0;
    at = next_addr;
    case (m)
      ModeStart: begin
        at = cfg_base;
        n = fill_words(at, cfg_start);
        r = '{1'b1, at, 32'd0, n, 1'b0, 1'b0};
        next_addr = at + (32'(n) << 2);
        lit_left = '0;
        partial = '0;
        err_seen = 1'b0;
      end
      ModeFinish: begin
        n = fill_words(at, cfg_stop);
        r = '{1'b1, at, 32'd0, n, 1'b1, (err_seen || lit_left != '0)};
        next_addr = at + (32'(n) << 2);
        lit_left = '0;
        partial = '0;
        err_seen = 1'b0;
      end
      ModeIgnore: begin
      end
      default: begin
        if (lit_left != '0) begin
          // last byte of a big-endian literal word
          if (lit_left[1:0] == 2'd1) begin
            r = '{1'b1, at, {partial, b}, 31'd1, 1'b0, 1'b0};
            next_addr = at + 32'd4;
            partial = '0;
          end else begin
            partial = {partial[15:0], b};
          end
          lit_left = lit_left - 11'd1;
        end else if (b < cfg_zero && b < cfg_lit) begin
          err_seen = 1'b1;
        end else if (b < cfg_zero) begin
          lit_left = (11'(b) - 11'(cfg_lit) + 11'd1) << 2;
          partial = '0;
        end else if (b < cfg_nop) begin
          n = 31'(b - cfg_zero) + 31'd1;
          r = '{1'b1, at, 32'd0, n, 1'b0, 1'b0};
          next_addr = at + (32'(n) << 2);
        end else begin
          n = 31'(b - cfg_nop) + 31'd1;
          r = '{1'b1, at, NopWord, n, 1'b0, 1'b0};
          next_addr = at + (32'(n) << 2);
        end
      end
    endcase
    return r;
  endfunction

  function automatic void match_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      failed = 1'b1;
    end
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.base = pick_addr();
    c.start = ($urandom_range(0, 3) == 0) ? pick_addr() : c.base + $urandom_range(0, 64);
    c.stop = ($urandom_range(0, 3) == 0) ? pick_addr() : c.start + $urandom_range(0, 8192);
    if ($urandom_range(0, 4) == 0) begin
      c.lit = 8'($urandom);
      c.zero = 8'($urandom);
      c.nop = 8'($urandom);
    end else begin
      c.lit = 8'($urandom_range(0, 40));
      c.zero = c.lit + 8'($urandom_range(1, 140));
      c.nop = c.zero + 8'($urandom_range(1, 255 - c.zero));
    end
    return c;
  endfunction

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic load_config(cfg_t c);
    cfg_base = c.base;
    cfg_start = c.start;
    cfg_stop = c.stop;
    cfg_lit = c.lit;
    cfg_zero = c.zero;
    cfg_nop = c.nop;
    write_reg(CfgBaseAddress, c.base);
    write_reg(CfgStartAddress, c.start);
    write_reg(CfgEndAddress, c.stop);
    write_reg(CfgLiteralBase, {24'd0, c.lit});
    write_reg(CfgZeroBase, {24'd0, c.zero});
    write_reg(CfgNopBase, {24'd0, c.nop});
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_item(mode_e m, logic [7:0] b, result_t pin);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    pin_q.push_back(pin);
    in_if.valid <= 1'b1;
    in_if.mode <= m;
    in_if.stream_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // wait out every pending run, then the pipeline stage behind it
  task automatic settle();
    in_if.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    for (int k = 0; k < 4000 && want_q.size() != 0; k++) @(posedge clk_i);
    if (want_q.size() != 0) begin
      $error("%0d runs never came out", want_q.size());
      failed = 1'b1;
      want_q.delete();
    end
    repeat (3) @(posedge clk_i);
  endtask

  // one opcode with its data, or a piece of noise; n counts decoded items
  task automatic send_run(output int unsigned n);
    int unsigned pick;
    int unsigned span;
    int unsigned words;
    int unsigned lo;
    int unsigned hi;
    n = 1;
    pick = $urandom_range(0, 99);
    lo = (cfg_lit < cfg_zero) ? cfg_lit : cfg_zero;
    hi = (cfg_zero > cfg_nop) ? cfg_zero : cfg_nop;
    if (pick < 40 && cfg_lit < cfg_zero) begin
      span = cfg_zero - cfg_lit;
      words = ($urandom_range(0, 99) == 0) ? $urandom_range(1, span)
                                           : $urandom_range(1, (span < 4) ? span : 4);
      push_item(ModeByte, 8'(cfg_lit + words - 1), '0);
      for (int k = 0; k < words * 4; k++) begin
        // now and then a literal is cut short
        if ($urandom_range(0, 299) == 0) break;
        push_item(ModeByte, 8'($urandom), '0);
        n++;
      end
    end else if (pick < 60 && cfg_zero < cfg_nop) begin
      push_item(ModeByte, 8'($urandom_range(cfg_zero, cfg_nop - 1)), '0);
    end else if (pick < 80) begin
      push_item(ModeByte, 8'($urandom_range(hi, 255)), '0);
    end else if (pick < 87 && lo != 0) begin
      push_item(ModeByte, 8'($urandom_range(0, lo - 1)), '0);
    end else if (pick < 92) begin
      push_item(ModeIgnore, 8'($urandom), '0);
      n = 0;
    end else if (pick < 94) begin
      push_item(ModeFinish, 8'($urandom), '0);
    end else begin
      push_item(ModeByte, 8'($urandom), '0);
    end
  endtask

  always @(posedge clk_i) begin : track_runs
    result_t guess;
    result_t pin;
    result_t want;
    if (in_if.valid && in_if.ready) begin
      guess = expand_item(mode_e'(in_if.mode), in_if.stream_byte);
      pin = (pin_q.size() != 0) ? pin_q.pop_front() : '0;
      if (pin.valid) guess = pin;
      if (guess.valid) want_q.push_back(guess);
    end
    if (out_if.valid && out_if.ready) begin
      if (want_q.size() == 0) begin
        $error("run at %h with nothing expected", out_if.word_address);
        failed = 1'b1;
      end else begin
        want = want_q.pop_front();
        match_field("word_address", want.word_address, out_if.word_address);
        match_field("word_value", want.word_value, out_if.word_value);
        match_field("repeat_count", 32'(want.repeat_count), 32'(out_if.repeat_count));
        match_field("last_run", 32'(want.last_run), 32'(out_if.last_run));
        match_field("format_error", 32'(want.format_error), 32'(out_if.format_error));
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles--;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_if.ready <= 1'b0;
      hold_cycles = $urandom_range(1, 13) - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [1:0]  phase_now;
    int unsigned sent;
    int unsigned n;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgBaseAddress;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.mode = ModeStart;
    in_if.stream_byte = '0;
    out_if.ready = 1'b0;
    phase_now = 2'd0;

    phase_cfg = '{
      '{32'h0, 32'h0, 32'h0, LiteralBaseReset, ZeroBaseReset, NopBaseReset},
      '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h10, 8'h20, 8'h30},
      '{32'hFFFF_FFF0, 32'hFFFF_FFF8, 32'h8, 8'hFF, 8'h40, 8'h10},
      '{32'h1000, 32'h1003, 32'h0, 8'h00, 8'h00, 8'h00}
    };

    dir_rows = '{
      // reset registers: start, no-op runs, zero runs, one literal word, ignore, finish
      '{2'd0, ModeStart,  8'h00, '{1'b1, 32'h0, 32'h0, 31'd0, 1'b0, 1'b0}},
      '{2'd0, ModeByte,   8'hC0, '{1'b1, 32'h0, NopWord, 31'd1, 1'b0, 1'b0}},
      '{2'd0, ModeByte,   8'hFF, '{1'b1, 32'h4, NopWord, 31'd64, 1'b0, 1'b0}},
      '{2'd0, ModeByte,   8'h80, '0},
      '{2'd0, ModeByte,   8'hBF, '0},
      '{2'd0, ModeByte,   8'h00, '0},
      '{2'd0, ModeByte,   8'hDE, '0},
      '{2'd0, ModeByte,   8'hAD, '0},
      '{2'd0, ModeByte,   8'hBE, '0},
      '{2'd0, ModeByte,   8'hEF, '0},
      '{2'd0, ModeIgnore, 8'hFF, '0},
      '{2'd0, ModeFinish, 8'h00, '0},
      // literal left open at finish
      '{2'd0, ModeByte,   8'h01, '0},
      '{2'd0, ModeByte,   8'h00, '0},
      '{2'd0, ModeByte,   8'hFF, '0},
      '{2'd0, ModeByte,   8'h7F, '0},
      '{2'd0, ModeFinish, 8'h00, '0},
      // widest fill, then an opcode below the literal base
      '{2'd1, ModeStart,  8'h00, '{1'b1, 32'h0, 32'h0, 31'h4000_0000, 1'b0, 1'b0}},
      '{2'd1, ModeByte,   8'h05, '0},
      '{2'd1, ModeByte,   8'h2F, '0},
      '{2'd1, ModeFinish, 8'h00, '0},
      // bases out of order, address wrap
      '{2'd2, ModeStart,  8'h00, '{1'b1, 32'hFFFF_FFF0, 32'h0, 31'd2, 1'b0, 1'b0}},
      '{2'd2, ModeByte,   8'hFF, '0},
      '{2'd2, ModeByte,   8'h00, '0},
      '{2'd2, ModeFinish, 8'h00, '0},
      // all bases zero, start not word aligned
      '{2'd3, ModeStart,  8'h00, '{1'b1, 32'h1000, 32'h0, 31'd1, 1'b0, 1'b0}},
      '{2'd3, ModeByte,   8'h00, '0},
      '{2'd3, ModeFinish, 8'h00, '0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumRows; i++) begin
      if (dir_rows[i].phase != phase_now) begin
        settle();
        load_config(phase_cfg[dir_rows[i].phase]);
        phase_now = dir_rows[i].phase;
      end
      push_item(dir_rows[i].mode, dir_rows[i].code, dir_rows[i].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      calm = (ph == 5);
      load_config(random_cfg());
      // some images stream without a start item
      if ($urandom_range(0, 7) != 0) push_item(ModeStart, 8'($urandom), '0);
      sent = 0;
      while (sent < 80) begin
        send_run(n);
        sent += n;
      end
      push_item(ModeFinish, 8'($urandom), '0);
    end

    settle();
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
